>>> rtl/core/svig_pkg.sv
// svig_pkg: types, constants and arithmetic helpers for the sphere vertex index generator
// no dependencies; used by the channel interfaces and the top level

package svig_pkg;

   localparam int CFG_W = 9;
   localparam int IDX_IN_W = 9;
   localparam int POS_W = 16;
   localparam int VIDX_W = 17;

   localparam logic [CFG_W-1:0] MAX_STACKS = 9'd256;
   localparam logic [CFG_W-1:0] MAX_SECTORS = 9'd256;
   localparam logic [CFG_W-1:0] STACK_RESET = 9'd16;
   localparam logic [CFG_W-1:0] SECTOR_RESET = 9'd32;

   localparam logic REG_STACK_COUNT = 1'b0;
   localparam logic REG_SECTOR_COUNT = 1'b1;

   localparam int PH_W = 18;
   localparam logic [PH_W-1:0] QUARTER = 18'd65536;
   localparam int NUM_W = 27;

   localparam int DIV_STAGES = 9;
   localparam int DIV_STEPS = 3;
   localparam int SG_PHASE = DIV_STAGES + 1;
   localparam int HORNER_N = 6;
   localparam int SG_ROUND = SG_PHASE + HORNER_N + 1;
   localparam int SG_MUL = SG_ROUND + 1;
   localparam int SG_OUT = SG_MUL + 1;
   localparam int NUM_STAGES = SG_OUT + 1;
   localparam int LANES = 4;

   localparam logic [30:0] HORNER_K [5] = '{
      31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   typedef struct packed {
      logic              in_range;
      logic              quad_valid;
      logic [VIDX_W-1:0] top_left;
      logic [VIDX_W-1:0] bottom_left;
      logic [VIDX_W-1:0] top_right;
      logic [VIDX_W-1:0] bottom_right;
   } side_type;

   typedef struct packed {
      logic [CFG_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_type;

   function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] v, logic [CFG_W-1:0] maxv);
      if (v == '0) return 9'd1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // one restoring division step, quotient bit shifts in at the bottom of num
   function automatic div_type div_step(div_type d, logic [CFG_W-1:0] divisor);
      logic [CFG_W:0] r;
      logic           q;
      div_type        o;
      r = {d.rem, d.num[NUM_W-1]};
      q = (r >= {1'b0, divisor});
      if (q) r = r - {1'b0, divisor};
      o.rem = r[CFG_W-1:0];
      o.num = {d.num[NUM_W-2:0], q};
      return o;
   endfunction

   function automatic logic [30:0] sub_floor0(logic [30:0] a, logic [31:0] b);
      if ({1'b0, a} < b) return '0;
      return 31'({1'b0, a} - b);
   endfunction

endpackage

>>> rtl/core/svig_req_if.sv
// svig_req_if: request channel carrying one grid point (stack and sector index)
// depends on svig_pkg

interface svig_req_if;
   import svig_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_IN_W-1:0] stack_index;
   logic [IDX_IN_W-1:0] sector_index;
   modport source (output valid, stack_index, sector_index, input ready);
   modport sink (input valid, stack_index, sector_index, output ready);
endinterface

>>> rtl/core/svig_rsp_if.sv
// svig_rsp_if: response channel carrying position and quad indices of one grid point
// depends on svig_pkg

interface svig_rsp_if;
   import svig_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic                     in_range;
   logic                     quad_valid;
   logic [VIDX_W-1:0]        index_top_left;
   logic [VIDX_W-1:0]        index_bottom_left;
   logic [VIDX_W-1:0]        index_top_right;
   logic [VIDX_W-1:0]        index_bottom_right;
   modport source (output valid, pos_x, pos_y, pos_z, in_range, quad_valid, index_top_left,
                   index_bottom_left, index_top_right, index_bottom_right, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, in_range, quad_valid, index_top_left,
                 index_bottom_left, index_top_right, index_bottom_right, output ready);
endinterface

>>> rtl/core/sphere_vertex_index_generator.sv
// sphere_vertex_index_generator: UV sphere grid point to Q1.15 position and quad indices
// depends on svig_pkg, svig_req_if, svig_rsp_if
//
// Usage:
//   req carries a stack and sector index; rsp returns the unit-sphere position (Q1.15)
//   of that grid point plus the four vertex indices of the quad it starts.
//   csr_wr_en/csr_index/csr_data write stack_count (index 0) and sector_count (index 1);
//   write them only while no transfer is in flight.
//   The datapath is a 20-stage pipeline: a 9-stage divider (3 quotient bits per stage)
//   forms the phases, four sine lanes evaluate a degree-9 polynomial with one multiply
//   per stage, and two product stages form x and y.
//   Throughput: one grid point per cycle while the receiver keeps rsp.ready high.
//   Each stage advances when it is empty or the stage after it advances, so when the
//   receiver stalls, bubbles are squeezed out and req.ready falls only once every
//   stage holds an item; nothing is lost or repeated.
//   Reset empties the pipeline and sets stack_count 16 and sector_count 32.

module sphere_vertex_index_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [svig_pkg::CFG_W-1:0]    csr_data,
   svig_req_if.sink                      req,
   svig_rsp_if.source                    rsp
);
   import svig_pkg::*;

   logic [CFG_W-1:0] stack_count_ff;
   logic [CFG_W-1:0] sector_count_ff;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] en;

   // stage 0 and divider stages
   logic [IDX_IN_W-1:0] i0_ff, j0_ff;
   logic [CFG_W-1:0]    s_ff [0:DIV_STAGES];
   logic [CFG_W-1:0]    t_ff [0:DIV_STAGES];
   div_type             da_ff [0:DIV_STAGES];
   div_type             db_ff [0:DIV_STAGES];
   logic [CFG_W-1:0]    s_in, t_in;

   side_type side_ff [1:NUM_STAGES-1];
   side_type side_in;

   // sine lanes: 0 sin(a), 1 cos(a), 2 cos(b), 3 sin(b)
   logic [16:0] hx_ff   [0:HORNER_N][LANES];
   logic        hneg_ff [0:HORNER_N][LANES];
   logic [30:0] hz_ff   [1:HORNER_N][LANES];
   logic [61:0] hprod_ff [2:HORNER_N][LANES];

   logic [14:0] rmag_ff [LANES];
   logic        rsgn_ff [LANES];

   logic [29:0] mx_ff, my_ff;
   logic        negx_ff, negy_ff;
   logic [14:0] zmag_ff;
   logic        zsgn_ff;

   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= STACK_RESET;
         sector_count_ff <= SECTOR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_STACK_COUNT: stack_count_ff <= csr_data;
            REG_SECTOR_COUNT: sector_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables ripple back from the output
   always_comb begin
      en[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | rsp.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = ~vld_ff[k] | en[k+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req.valid;
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 0: capture and form rounded numerators
   always_comb begin
      s_in = clamp_count(stack_count_ff, MAX_STACKS);
      t_in = clamp_count(sector_count_ff, MAX_SECTORS);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         i0_ff <= req.stack_index;
         j0_ff <= req.sector_index;
         s_ff[0] <= s_in;
         t_ff[0] <= t_in;
         da_ff[0].rem <= '0;
         da_ff[0].num <= {1'b0, req.stack_index, 17'd0} + NUM_W'(s_in >> 1);
         db_ff[0].rem <= '0;
         db_ff[0].num <= {req.sector_index, 18'd0} + NUM_W'(t_in >> 1);
      end
   end

   for (genvar gk = 1; gk <= DIV_STAGES; gk++) begin : g_div
      div_type da, db;
      always_comb begin
         da = da_ff[gk-1];
         db = db_ff[gk-1];
         for (int st = 0; st < DIV_STEPS; st++) begin
            da = div_step(da, s_ff[gk-1]);
            db = div_step(db, t_ff[gk-1]);
         end
      end
      always_ff @(posedge clock) begin
         if (en[gk]) begin
            da_ff[gk] <= da;
            db_ff[gk] <= db;
            s_ff[gk] <= s_ff[gk-1];
            t_ff[gk] <= t_ff[gk-1];
         end
      end
   end

   // vertex indices, formed in stage 1 and carried alongside
   always_comb begin
      logic [9:0]        t_plus;
      logic [18:0]       tl_prod;
      logic [VIDX_W-1:0] tl, bl;
      t_plus = {1'b0, t_ff[0]} + 10'd1;
      tl_prod = i0_ff * t_plus;
      tl = tl_prod[VIDX_W-1:0] + {8'd0, j0_ff};
      bl = tl + {7'd0, t_plus};
      side_in.in_range = (i0_ff <= s_ff[0]) && (j0_ff <= t_ff[0]);
      side_in.quad_valid = (i0_ff < s_ff[0]) && (j0_ff < t_ff[0]);
      side_in.top_left = tl;
      side_in.bottom_left = bl;
      side_in.top_right = tl + 17'd1;
      side_in.bottom_right = bl + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) side_ff[1] <= side_in;
      for (int k = 2; k < NUM_STAGES; k++) begin
         if (en[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   // phase stage: quadrant folding
   always_ff @(posedge clock) begin
      logic [PH_W-1:0] ph [LANES];
      if (en[SG_PHASE]) begin
         ph[0] = da_ff[DIV_STAGES].num[PH_W-1:0];
         ph[1] = da_ff[DIV_STAGES].num[PH_W-1:0] + QUARTER;
         ph[2] = db_ff[DIV_STAGES].num[PH_W-1:0] + QUARTER;
         ph[3] = db_ff[DIV_STAGES].num[PH_W-1:0];
         for (int l = 0; l < LANES; l++) begin
            hx_ff[0][l] <= ph[l][16] ? 17'(18'd65536 - {2'b00, ph[l][15:0]})
                                     : {1'b0, ph[l][15:0]};
            hneg_ff[0][l] <= ph[l][17];
         end
      end
   end

   // z = x*x/4
   always_ff @(posedge clock) begin
      logic [33:0] sq;
      if (en[SG_PHASE+1]) begin
         for (int l = 0; l < LANES; l++) begin
            sq = hx_ff[0][l] * hx_ff[0][l];
            hz_ff[1][l] <= sq[32:2];
            hx_ff[1][l] <= hx_ff[0][l];
            hneg_ff[1][l] <= hneg_ff[0][l];
         end
      end
   end

   // Horner steps, one multiply per stage
   for (genvar gn = 2; gn <= HORNER_N; gn++) begin : g_horner
      logic [30:0] hk [LANES];
      if (gn == 2) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) hk[l] = HORNER_K[0];
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               hk[l] = sub_floor0(HORNER_K[gn-2], hprod_ff[gn-1][l][61:30]);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en[SG_PHASE+gn]) begin
            for (int l = 0; l < LANES; l++) begin
               if (gn == HORNER_N) hprod_ff[gn][l] <= hk[l] * hx_ff[gn-1][l];
               else hprod_ff[gn][l] <= hk[l] * hz_ff[gn-1][l];
               hz_ff[gn][l] <= hz_ff[gn-1][l];
               hx_ff[gn][l] <= hx_ff[gn-1][l];
               hneg_ff[gn][l] <= hneg_ff[gn-1][l];
            end
         end
      end
   end

   // round to Q15 and saturate
   always_ff @(posedge clock) begin
      logic [48:0] sum;
      logic [14:0] mag;
      if (en[SG_ROUND]) begin
         for (int l = 0; l < LANES; l++) begin
            sum = {1'b0, hprod_ff[HORNER_N][l][47:0]} + 49'h0_4000_0000;
            mag = (sum[48:31] > 18'd32767) ? 15'h7fff : sum[45:31];
            rmag_ff[l] <= mag;
            rsgn_ff[l] <= hneg_ff[HORNER_N][l] && (mag != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[SG_MUL]) begin
         mx_ff <= rmag_ff[0] * rmag_ff[2];
         my_ff <= rmag_ff[0] * rmag_ff[3];
         negx_ff <= rsgn_ff[0] ^ rsgn_ff[2];
         negy_ff <= rsgn_ff[0] ^ rsgn_ff[3];
         zmag_ff <= rmag_ff[1];
         zsgn_ff <= rsgn_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      logic [29:0] rx, ry;
      if (en[SG_OUT]) begin
         rx = mx_ff + 30'd16384;
         ry = my_ff + 30'd16384;
         pos_x_ff <= negx_ff ? -$signed({1'b0, rx[29:15]}) : $signed({1'b0, rx[29:15]});
         pos_y_ff <= negy_ff ? -$signed({1'b0, ry[29:15]}) : $signed({1'b0, ry[29:15]});
         pos_z_ff <= zsgn_ff ? -$signed({1'b0, zmag_ff}) : $signed({1'b0, zmag_ff});
      end
   end

   assign rsp.valid = vld_ff[SG_OUT];
   assign rsp.pos_x = pos_x_ff;
   assign rsp.pos_y = pos_y_ff;
   assign rsp.pos_z = pos_z_ff;
   assign rsp.in_range = side_ff[SG_OUT].in_range;
   assign rsp.quad_valid = side_ff[SG_OUT].quad_valid;
   assign rsp.index_top_left = side_ff[SG_OUT].top_left;
   assign rsp.index_bottom_left = side_ff[SG_OUT].bottom_left;
   assign rsp.index_top_right = side_ff[SG_OUT].top_right;
   assign rsp.index_bottom_right = side_ff[SG_OUT].bottom_right;

   a_quad_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.quad_valid |-> rsp.in_range)
      else $error("quad_valid without in_range");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.pos_x != -16'sd32768) && (rsp.pos_y != -16'sd32768)
                    && (rsp.pos_z != -16'sd32768))
      else $error("position outside Q1.15 unit range");

   a_right_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.index_top_right == rsp.index_top_left + 17'd1)
                    && (rsp.index_bottom_right == rsp.index_bottom_left + 17'd1))
      else $error("right column index mismatch");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready && (&vld_ff) |-> !req.ready)
      else $error("request taken with a full stalled pipeline");

endmodule
